// ----- rtl/flash_write_back_sector_cache_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the flash write-back sector cache
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef FLASH_WRITE_BACK_SECTOR_CACHE_UNIT_ASSERT_SVH
`define FLASH_WRITE_BACK_SECTOR_CACHE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FWSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fwsc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FWSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fwsc assertion failed");

`endif

// ----- rtl/fwsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fwsc_pkg
// Shared types, codes and defaults of the flash write-back sector cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fwsc_pkg;

  localparam int NUM_SECTORS_DEF  = 4;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int PAGE_BYTES_DEF   = 256;

  localparam int MODE_W  = 3;
  localparam int ADDR_FW = 16;
  localparam int DATA_W  = 8;
  localparam int KIND_W  = 2;
  localparam int SECT_FW = 2;
  localparam int MASK_W  = 16;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [DATA_W-1:0] FLUSH_DELAY_RESET = 8'd5;
  localparam logic [DATA_W-1:0] BLANK_BYTE        = 8'hFF;

  localparam logic [MODE_W-1:0] MODE_READ    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLUSH   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PRELOAD = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE,
    OP_PRELOAD,
    OP_TICK,
    OP_FLUSH,
    OP_RANGE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_FW-1:0] addr;
    logic [DATA_W-1:0]  data;
  } cmd_t;

endpackage

// ----- rtl/fwsc_front.sv -----
// ----------------------------------------------------------------------------
// fwsc_front
// Accepts input words, decodes the mode, checks the address range and
// pushes one command per meaningful word into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwsc_front #(
  parameter int MEM_DEPTH = fwsc_pkg::NUM_SECTORS_DEF * fwsc_pkg::SECTOR_BYTES_DEF
) (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fwsc_pkg::MODE_W-1:0]  in_mode,
  input  logic [fwsc_pkg::ADDR_FW-1:0] in_address,
  input  logic [fwsc_pkg::DATA_W-1:0]  in_data,
  input  logic                         q_full,
  output logic                         q_push,
  output fwsc_pkg::cmd_t               q_cmd
);

  logic in_range;
  logic known;

  assign in_stall = q_full;
  assign in_range = 32'(in_address) < 32'(MEM_DEPTH);

  always_comb begin
    known      = 1'b1;
    q_cmd.addr = in_address;
    q_cmd.data = in_data;
    q_cmd.op   = fwsc_pkg::OP_READ;
    case (in_mode)
      fwsc_pkg::MODE_READ: begin
        q_cmd.op = in_range ? fwsc_pkg::OP_READ : fwsc_pkg::OP_RANGE;
      end
      fwsc_pkg::MODE_WRITE: begin
        q_cmd.op = in_range ? fwsc_pkg::OP_WRITE : fwsc_pkg::OP_RANGE;
      end
      fwsc_pkg::MODE_PRELOAD: begin
        q_cmd.op = in_range ? fwsc_pkg::OP_PRELOAD : fwsc_pkg::OP_RANGE;
      end
      fwsc_pkg::MODE_TICK: begin
        q_cmd.op = fwsc_pkg::OP_TICK;
      end
      fwsc_pkg::MODE_FLUSH: begin
        q_cmd.op = fwsc_pkg::OP_FLUSH;
      end
      default: begin
        // Undefined modes are taken and dropped without any effect.
        known = 1'b0;
      end
    endcase
  end

  assign q_push = in_valid && !q_full && known;

endmodule

// ----- rtl/fwsc_fifo.sv -----
// ----------------------------------------------------------------------------
// fwsc_fifo
// Short command queue between the decode front and the cache back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwsc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fwsc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output fwsc_pkg::cmd_t pop_cmd
);

  localparam int DEPTH = fwsc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fwsc_pkg::cmd_t   entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = count_r == CNT_W'(DEPTH);
  assign valid   = count_r != '0;
  assign pop_cmd = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/fwsc_back.sv -----
// ----------------------------------------------------------------------------
// fwsc_back
// Cache back end: byte memory, dirty flags, uptime and change stamp,
// flush sequencer with page blank scan, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwsc_back #(
  parameter int NUM_SECTORS  = fwsc_pkg::NUM_SECTORS_DEF,
  parameter int SECTOR_BYTES = fwsc_pkg::SECTOR_BYTES_DEF,
  parameter int PAGE_BYTES   = fwsc_pkg::PAGE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fwsc_pkg::DATA_W-1:0]  cfg_wdata,
  input  logic                         q_valid,
  input  fwsc_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fwsc_pkg::KIND_W-1:0]  out_kind,
  output logic [fwsc_pkg::DATA_W-1:0]  out_read_data,
  output logic [fwsc_pkg::SECT_FW-1:0] out_sector,
  output logic [fwsc_pkg::MASK_W-1:0]  out_page_mask,
  output logic                         out_last
);

  localparam int MEM_DEPTH   = NUM_SECTORS * SECTOR_BYTES;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int SEC_W       = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
  localparam int SEC_CW      = $clog2(NUM_SECTORS + 1);
  localparam int SB_W        = $clog2(SECTOR_BYTES);
  localparam int OFW         = $clog2(PAGE_BYTES);
  localparam int NPAGES      = SECTOR_BYTES / PAGE_BYTES;
  localparam int NPAGES_SCAN = (NPAGES < fwsc_pkg::MASK_W) ? NPAGES : fwsc_pkg::MASK_W;
  localparam int PC_W        = $clog2(NPAGES_SCAN + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_SEARCH,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                         state_r, state_nxt;
  fwsc_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [NUM_SECTORS-1:0]         dirty_r, dirty_nxt;
  logic [31:0]                    uptime_r, uptime_nxt;
  logic [31:0]                    lct_r, lct_nxt;
  logic [fwsc_pkg::DATA_W-1:0]    delay_r, delay_nxt;
  logic [SEC_CW-1:0]              sec_r, sec_nxt;
  logic [PC_W-1:0]                iss_page_r, iss_page_nxt;
  logic [OFW-1:0]                 iss_off_r, iss_off_nxt;
  logic                           chk_valid_r, chk_valid_nxt;
  logic [PC_W-1:0]                chk_page_r, chk_page_nxt;
  logic [fwsc_pkg::MASK_W-1:0]    mask_r, mask_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [fwsc_pkg::KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [fwsc_pkg::DATA_W-1:0]    out_rdata_r, out_rdata_nxt;
  logic [fwsc_pkg::SECT_FW-1:0]   out_sector_r, out_sector_nxt;
  logic [fwsc_pkg::MASK_W-1:0]    out_mask_r, out_mask_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [fwsc_pkg::DATA_W-1:0]    mem [MEM_DEPTH];
  logic [fwsc_pkg::DATA_W-1:0]    rd_data_r;
  logic                           mem_re;
  logic [ADDR_W-1:0]              mem_raddr;
  logic                           mem_we;
  logic [ADDR_W-1:0]              mem_waddr;

  logic                           out_free;
  logic [31:0]                    up_inc;
  logic [32:0]                    due_sum;
  logic                           tick_due;
  logic [SEC_W-1:0]               acc_sec;
  logic [SEC_W-1:0]               cur_sec;
  logic [NUM_SECTORS-1:0]         cur_onehot;
  logic [31:0]                    scan_addr;
  logic                           issuing;
  logic                           hit;

  assign out_free   = !out_valid_r || !out_stall;
  assign up_inc     = uptime_r + 32'd1;
  assign due_sum    = {1'b0, lct_r} + 33'(delay_r);
  // The stamp plus delay is compared without wrap against the new uptime.
  assign tick_due   = (lct_r != 32'd0) && (due_sum < {1'b0, up_inc});
  assign acc_sec    = SEC_W'(cmd_r.addr >> SB_W);
  assign cur_sec    = sec_r[SEC_W-1:0];
  assign cur_onehot = NUM_SECTORS'(1) << cur_sec;
  assign scan_addr  = (32'(cur_sec) << SB_W) | (32'(iss_page_r) << OFW) | 32'(iss_off_r);
  assign issuing    = iss_page_r != PC_W'(NPAGES_SCAN);
  assign hit        = chk_valid_r && (rd_data_r != fwsc_pkg::BLANK_BYTE);
  assign mem_waddr  = cmd_r.addr[ADDR_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    dirty_nxt      = dirty_r;
    uptime_nxt     = uptime_r;
    lct_nxt        = lct_r;
    delay_nxt      = cfg_we ? cfg_wdata : delay_r;
    sec_nxt        = sec_r;
    iss_page_nxt   = iss_page_r;
    iss_off_nxt    = iss_off_r;
    chk_valid_nxt  = chk_valid_r;
    chk_page_nxt   = chk_page_r;
    mask_nxt       = mask_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_rdata_nxt  = out_rdata_r;
    out_sector_nxt = out_sector_r;
    out_mask_nxt   = out_mask_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = q_cmd.addr[ADDR_W-1:0];
    mem_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            fwsc_pkg::OP_READ, fwsc_pkg::OP_WRITE, fwsc_pkg::OP_PRELOAD: begin
              q_pop     = 1'b1;
              mem_re    = 1'b1;
              cmd_nxt   = q_cmd;
              state_nxt = S_ACC;
            end
            fwsc_pkg::OP_RANGE: begin
              if (out_free) begin
                q_pop          = 1'b1;
                out_valid_nxt  = 1'b1;
                out_kind_nxt   = fwsc_pkg::KIND_RANGE;
                out_rdata_nxt  = '0;
                out_sector_nxt = '0;
                out_mask_nxt   = '0;
                out_last_nxt   = 1'b1;
              end
            end
            fwsc_pkg::OP_TICK: begin
              q_pop      = 1'b1;
              uptime_nxt = up_inc;
              if (tick_due) begin
                lct_nxt   = '0;
                sec_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            fwsc_pkg::OP_FLUSH: begin
              q_pop     = 1'b1;
              lct_nxt   = '0;
              sec_nxt   = '0;
              state_nxt = S_SEARCH;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end

      S_ACC: begin
        // The cached byte read when the command was taken is now in rd_data_r.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = fwsc_pkg::KIND_ACCESS;
          out_sector_nxt = '0;
          out_mask_nxt   = '0;
          out_last_nxt   = 1'b1;
          case (cmd_r.op)
            fwsc_pkg::OP_WRITE: begin
              out_rdata_nxt = cmd_r.data;
              if (rd_data_r != cmd_r.data) begin
                mem_we             = 1'b1;
                dirty_nxt[acc_sec] = 1'b1;
                lct_nxt            = uptime_r;
              end
            end
            fwsc_pkg::OP_PRELOAD: begin
              out_rdata_nxt = cmd_r.data;
              mem_we        = 1'b1;
            end
            default: begin
              out_rdata_nxt = rd_data_r;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end

      S_SEARCH: begin
        if (sec_r == SEC_CW'(NUM_SECTORS)) begin
          state_nxt = S_IDLE;
        end else if (dirty_r[cur_sec]) begin
          iss_page_nxt  = '0;
          iss_off_nxt   = '0;
          chk_valid_nxt = 1'b0;
          mask_nxt      = '0;
          state_nxt     = S_SCAN;
        end else begin
          sec_nxt = sec_r + 1'b1;
        end
      end

      S_SCAN: begin
        // One byte is read per cycle unless a hit moves on a page, and is checked in
        // the next cycle; a page stops being read once one byte is found non-blank.
        chk_valid_nxt = 1'b0;
        if (hit) begin
          mask_nxt = mask_r | (fwsc_pkg::MASK_W'(1) << chk_page_r);
        end
        if (issuing) begin
          if (hit && (chk_page_r == iss_page_r)) begin
            iss_page_nxt = iss_page_r + 1'b1;
            iss_off_nxt  = '0;
          end else begin
            mem_re        = 1'b1;
            mem_raddr     = scan_addr[ADDR_W-1:0];
            chk_valid_nxt = 1'b1;
            chk_page_nxt  = iss_page_r;
            if (iss_off_r == OFW'(PAGE_BYTES - 1)) begin
              iss_page_nxt = iss_page_r + 1'b1;
              iss_off_nxt  = '0;
            end else begin
              iss_off_nxt = iss_off_r + 1'b1;
            end
          end
        end else if (!chk_valid_r) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = fwsc_pkg::KIND_FLUSH;
          out_rdata_nxt  = '0;
          out_sector_nxt = fwsc_pkg::SECT_FW'(cur_sec);
          out_mask_nxt   = mask_r;
          // Lower sectors are already clean, so this is the last command
          // when no other dirty flag remains.
          out_last_nxt   = (dirty_r & ~cur_onehot) == '0;
          dirty_nxt      = dirty_r & ~cur_onehot;
          sec_nxt        = sec_r + 1'b1;
          state_nxt      = S_SEARCH;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dirty_r     <= '0;
      uptime_r    <= '0;
      lct_r       <= '0;
      delay_r     <= fwsc_pkg::FLUSH_DELAY_RESET;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      uptime_r    <= uptime_nxt;
      lct_r       <= lct_nxt;
      delay_r     <= delay_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    sec_r        <= sec_nxt;
    iss_page_r   <= iss_page_nxt;
    iss_off_r    <= iss_off_nxt;
    chk_page_r   <= chk_page_nxt;
    mask_r       <= mask_nxt;
    out_kind_r   <= out_kind_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_sector_r <= out_sector_nxt;
    out_mask_r   <= out_mask_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd_r.data;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_read_data = out_rdata_r;
  assign out_sector    = out_sector_r;
  assign out_page_mask = out_mask_r;
  assign out_last      = out_last_r;

endmodule

// ----- rtl/flash_write_back_sector_cache_unit.sv -----
// ----------------------------------------------------------------------------
// flash_write_back_sector_cache_unit
// Write-back RAM cache of flash sectors with dirty tracking and flush scan.
// ----------------------------------------------------------------------------
// A byte read, write or preload is handled in the back end as a memory
// read, then compare, write and result, so the back end takes no new command
// until the access is through; an out-of-range access and a tick without a
// due flush are handled in the idle state, and the front drops an undefined
// mode. A flush steps through the sectors one per cycle and, for each dirty
// one, scans its reported pages one byte per cycle on the single memory
// read port, but for a cycle that moves on to the next page after a hit,
// leaving a page at its first non-blank byte. A two-entry command queue
// lets words be taken while the back end is busy. The byte memory has no
// reset and needs no clearing pass.
`timescale 1ns / 1ps

`include "flash_write_back_sector_cache_unit_assert.svh"

module flash_write_back_sector_cache_unit #(
  parameter int NUM_SECTORS  = fwsc_pkg::NUM_SECTORS_DEF,
  parameter int SECTOR_BYTES = fwsc_pkg::SECTOR_BYTES_DEF,
  parameter int PAGE_BYTES   = fwsc_pkg::PAGE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fwsc_pkg::DATA_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fwsc_pkg::MODE_W-1:0]  in_mode,
  input  logic [fwsc_pkg::ADDR_FW-1:0] in_address,
  input  logic [fwsc_pkg::DATA_W-1:0]  in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fwsc_pkg::KIND_W-1:0]  out_kind,
  output logic [fwsc_pkg::DATA_W-1:0]  out_read_data,
  output logic [fwsc_pkg::SECT_FW-1:0] out_sector,
  output logic [fwsc_pkg::MASK_W-1:0]  out_page_mask,
  output logic                         out_last
);

  logic           q_full;
  logic           q_push;
  fwsc_pkg::cmd_t push_cmd;
  logic           q_valid;
  logic           q_pop;
  fwsc_pkg::cmd_t q_cmd;
  logic           out_flush;
  logic           access_ok;
  logic           access_pop;

  fwsc_front #(
    .MEM_DEPTH (NUM_SECTORS * SECTOR_BYTES)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_address (in_address),
    .in_data    (in_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  fwsc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  fwsc_back #(
    .NUM_SECTORS  (NUM_SECTORS),
    .SECTOR_BYTES (SECTOR_BYTES),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_read_data (out_read_data),
    .out_sector    (out_sector),
    .out_page_mask (out_page_mask),
    .out_last      (out_last)
  );

  assign out_flush  = out_valid && (out_kind == fwsc_pkg::KIND_FLUSH);
  assign access_ok  = out_last && (out_page_mask == '0) && (out_sector == '0);
  assign access_pop = q_pop && ((q_cmd.op == fwsc_pkg::OP_READ) ||
                                (q_cmd.op == fwsc_pkg::OP_WRITE) ||
                                (q_cmd.op == fwsc_pkg::OP_PRELOAD));

  // Flush commands never carry read data.
  `FWSC_ASSERT_NOW(a_flush_no_data, out_flush, out_read_data == '0)
  // Access and range results are single words with no sector or mask.
  `FWSC_ASSERT_NOW(a_access_single, out_valid && !out_flush, access_ok)
  // The back end only takes commands the queue holds.
  `FWSC_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid)
  // A byte access keeps the back end busy, so no command is popped right behind it.
  `FWSC_ASSERT_NEXT(a_access_two_cycles, access_pop, !q_pop)

endmodule
